// ----- sv/wphp_pkg.sv -----
// Shared types and fixed widths for the waypoint heading projector.
package wphp_pkg;

   localparam int CRD_W     = 32;
   localparam int HD_W      = 16;
   localparam int P_W       = 21;
   localparam int NM_W      = 34;
   localparam int NV_W      = 34;
   localparam int ROOT_IN_W = 64;
   localparam int ROOT_W    = 32;
   localparam int DIV_DW    = 48;
   localparam int DIV_VW    = 32;
   localparam int MUL_AW    = 34;
   localparam int MUL_BW    = 17;
   localparam int MUL_PW    = MUL_AW + MUL_BW;
   localparam int DOT_W     = 50;

   typedef enum logic [4:0] {
      S_IDLE, S_DIFF, S_DSQ, S_DGO, S_DWAIT, S_NLOAD, S_NSHIFT, S_NSQ, S_NGO, S_NWAIT,
      S_QGO, S_QWAIT, S_NEXT, S_RGO, S_RWAIT, S_BLEND, S_DOT, S_PERP, S_PUSH, S_OUT
   } state_type;

endpackage

// ----- sv/waypoint_heading_projector.sv -----
// Waypoint heading projector: sequencer, heading state and shared serial units.
//
// Usage: one input transfer on the req_ channel carries the goal, previous waypoint and
// robot position (nine signed coordinates). The block updates its stored unit heading
// and returns one projected goal on the rsp_ channel. csr_wr_en/csr_wr_data write the
// projection distance; write it only while the block is idle.
// The time from the input transfer to rsp_tvalid depends mostly on the serial divider
// (up to seven quotients per item) and the serial square root (up to three roots per
// item); normalization shifts add to it as well.
// One item is processed at a time; req_tready is high only when the sequencer is idle,
// so a new item is accepted only after the previous one has reached the output register.
// A finished result waits in the output register; while the receiver stalls, the next
// item is already accepted and computed, and it waits for the output register to free.
// Reset clears the heading to zero, sets the projection distance to 1.6 m and drops
// any pending result.
module waypoint_heading_projector #(
   parameter int COORD_FRAC_BITS   = 16,
   parameter int HEADING_FRAC_BITS = 14
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // goal_x, goal_y, goal_z, prev_x, prev_y, prev_z, robot_x, robot_y, robot_z
   input  logic [9*wphp_pkg::CRD_W-1:0]      req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_x, out_y, out_z
   output logic [3*wphp_pkg::CRD_W-1:0]      rsp_tdata,
   input  logic                              csr_wr_en,
   input  logic [wphp_pkg::P_W-1:0]          csr_wr_data
);
   import wphp_pkg::*;

   localparam longint PD_RESET_L = ((longint'(16) << COORD_FRAC_BITS) + 5) / 10;
   localparam logic [P_W-1:0] PD_RESET = P_W'(PD_RESET_L);
   localparam logic [MUL_BW-1:0] HONE = MUL_BW'(1) << HEADING_FRAC_BITS;
   localparam logic [MUL_PW-1:0] PUSH_RND = MUL_PW'(1) << (HEADING_FRAC_BITS - 1);

   state_type state_ff, state_in;

   logic signed [CRD_W-1:0] goal_ff [3];
   logic signed [CRD_W-1:0] prev_ff [3];
   logic signed [CRD_W-1:0] robot_ff [3];
   logic [P_W-1:0]          p_ff, p_in;
   logic signed [HD_W-1:0]  heading_ff [3];
   logic signed [HD_W-1:0]  heading_in [3];
   logic signed [HD_W-1:0]  u_ff [3];
   logic signed [HD_W-1:0]  u_in [3];
   logic [NM_W-1:0]         nm_ff [3];
   logic [NM_W-1:0]         nm_in [3];
   logic                    neg_ff [3];
   logic                    neg_in [3];
   logic signed [NV_W-1:0]  nv_ff [3];
   logic signed [NV_W-1:0]  nv_in [3];
   logic                    same_ff, same_in, held_ff, held_in;
   logic [ROOT_W-1:0]       dist_ff, dist_in;
   logic [HD_W-1:0]         ratio_ff, ratio_in;
   logic [61:0]             prod_ff, prod_in;
   logic [ROOT_IN_W-1:0]    acc_ff, acc_in;
   logic signed [DOT_W-1:0] dacc_ff, dacc_in;
   logic [1:0]              cnt_ff, cnt_in;
   logic                    phase_ff, phase_in, pass_ff, pass_in;
   logic [CRD_W-1:0]        out_ff [3];
   logic [CRD_W-1:0]        out_in [3];
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [3*CRD_W-1:0]      rsp_data_ff, rsp_data_in;

   logic signed [CRD_W:0]   d_w [3];
   logic [CRD_W:0]          dmag_w [3];
   logic [NV_W-1:0]         nvmag_w [3];
   logic [HD_W-1:0]         nhm_w [3];
   logic signed [MUL_BW-1:0] t_w [3];
   logic                    big_w, same_w, held_w, any_hi, all_lo, nz_w;
   logic [1:0]              idx;
   logic [30:0]             sq_op;
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [MUL_PW-1:0] mul_p;
   logic signed [DOT_W-1:0] dsum;
   logic [CRD_W:0]          dist2;
   logic [P_W-1:0]          mn_w, pd_w;
   logic [DIV_DW-1:0]       rnum, qnum, quot;
   logic [HD_W-1:0]         o16;
   logic [MUL_PW-1:0]       pa_w;
   logic [NV_W-1:0]         delta_w, gx_w, po_w;
   logic                    dist_lt_p, accept;

   logic                    root_start, root_done, div_start, div_done;
   logic [ROOT_W-1:0]       root_w;
   logic [DIV_DW-1:0]       div_dividend;
   logic [DIV_VW-1:0]       div_divisor;

   wphp_isqrt #(.IN_W(ROOT_IN_W)) u_isqrt (
      .clock(clock), .reset(reset), .start(root_start), .radicand(acc_ff),
      .done(root_done), .root(root_w)
   );

   wphp_div #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(div_done), .quotient(quot)
   );

   assign accept = req_tvalid && req_tready;

   // Shared combinational terms.
   always_comb begin
      big_w  = 1'b0;
      same_w = 1'b1;
      any_hi = 1'b0;
      all_lo = 1'b1;
      nz_w   = 1'b1;
      for (int i = 0; i < 3; i++) begin
         d_w[i]     = {goal_ff[i][CRD_W-1], goal_ff[i]} - {robot_ff[i][CRD_W-1], robot_ff[i]};
         dmag_w[i]  = d_w[i][CRD_W] ? (CRD_W+1)'(-d_w[i]) : (CRD_W+1)'(d_w[i]);
         nvmag_w[i] = nv_ff[i][NV_W-1] ? NV_W'(-nv_ff[i]) : NV_W'(nv_ff[i]);
         nhm_w[i]   = heading_ff[i][HD_W-1] ? HD_W'(-heading_ff[i]) : HD_W'(heading_ff[i]);
         if (dmag_w[i][CRD_W:CRD_W-1] != 2'b00) big_w = 1'b1;
         if (goal_ff[i] != prev_ff[i]) same_w = 1'b0;
         if (nm_ff[i][NM_W-1:31] != '0) any_hi = 1'b1;
         if (nm_ff[i][NM_W-1:30] != '0) all_lo = 1'b0;
         if (nm_ff[i] != '0) nz_w = 1'b0;
      end
      held_w = (heading_ff[0] != '0) || (heading_ff[1] != '0) || (heading_ff[2] != '0);
      t_w[0] = {heading_ff[1][HD_W-1], heading_ff[1]};
      t_w[1] = MUL_BW'(-{heading_ff[0][HD_W-1], heading_ff[0]});
      t_w[2] = {heading_ff[2][HD_W-1], heading_ff[2]};

      idx   = (cnt_ff == 2'd3) ? 2'd0 : cnt_ff;
      sq_op = nm_ff[idx][30:0];

      dist2     = {dist_ff, 1'b0};
      mn_w      = (dist2 < (CRD_W+1)'(p_ff)) ? dist2[P_W-1:0] : p_ff;
      rnum      = (DIV_DW'(mn_w) << HEADING_FRAC_BITS) + DIV_DW'(p_ff >> 1);
      qnum      = (DIV_DW'(sq_op) << HEADING_FRAC_BITS) + DIV_DW'(root_w >> 1);
      dist_lt_p = dist_ff < ROOT_W'(p_ff);
      pd_w      = p_ff - dist_ff[P_W-1:0];

      // Clamp a normalized quotient into the signed heading range.
      if (neg_ff[idx]) begin
         o16 = (quot > DIV_DW'(32768)) ? 16'h8000 : HD_W'(-quot[HD_W-1:0]);
      end else begin
         o16 = (quot > DIV_DW'(32767)) ? 16'h7fff : quot[HD_W-1:0];
      end

      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_BLEND: begin
            if (!phase_ff) begin
               mul_a = {{(MUL_AW-HD_W){u_ff[idx][HD_W-1]}}, u_ff[idx]};
               mul_b = {1'b0, ratio_ff};
            end else begin
               mul_a = {{(MUL_AW-HD_W){heading_ff[idx][HD_W-1]}}, heading_ff[idx]};
               mul_b = HONE - {1'b0, ratio_ff};
            end
         end
         S_DOT: begin
            mul_a = nv_ff[idx];
            mul_b = {heading_ff[idx][HD_W-1], heading_ff[idx]};
         end
         S_PERP: begin
            mul_a = nv_ff[idx];
            mul_b = t_w[idx];
         end
         S_PUSH: begin
            mul_a = {{(MUL_AW-P_W){1'b0}}, pd_w};
            mul_b = {1'b0, nhm_w[idx]};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
      dsum  = dacc_ff + DOT_W'(mul_p);

      pa_w    = mul_p + PUSH_RND;
      delta_w = NV_W'(pa_w >> HEADING_FRAC_BITS);
      gx_w    = {{(NV_W-CRD_W){goal_ff[idx][CRD_W-1]}}, goal_ff[idx]};
      if (!dist_lt_p) po_w = gx_w;
      else if (heading_ff[idx][HD_W-1]) po_w = gx_w - delta_w;
      else po_w = gx_w + delta_w;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_tvalid) state_in = S_DIFF;
         S_DIFF:   state_in = big_w ? S_NLOAD : S_DSQ;
         S_DSQ:    if (cnt_ff == 2'd3) state_in = S_DGO;
         S_DGO:    state_in = S_DWAIT;
         S_DWAIT:  if (root_done) state_in = S_NLOAD;
         S_NLOAD:  state_in = S_NSHIFT;
         S_NSHIFT: begin
            if (nz_w) state_in = S_NEXT;
            else if (!any_hi && !all_lo) state_in = S_NSQ;
         end
         S_NSQ:    if (cnt_ff == 2'd3) state_in = S_NGO;
         S_NGO:    state_in = S_NWAIT;
         S_NWAIT:  if (root_done) state_in = S_QGO;
         S_QGO:    state_in = S_QWAIT;
         S_QWAIT:  if (div_done) state_in = (cnt_ff == 2'd2) ? S_NEXT : S_QGO;
         S_NEXT: begin
            if (pass_ff) state_in = S_PUSH;
            else if (same_ff && held_ff && p_ff != '0) state_in = S_RGO;
            else state_in = S_BLEND;
         end
         S_RGO:    state_in = S_RWAIT;
         S_RWAIT:  if (div_done) state_in = S_BLEND;
         S_BLEND:  if (cnt_ff == 2'd2 && phase_ff) state_in = S_DOT;
         S_DOT: begin
            if (cnt_ff == 2'd2) state_in = (held_ff && dsum < 0) ? S_PERP : S_NLOAD;
         end
         S_PERP:   if (cnt_ff == 2'd2) state_in = S_NLOAD;
         S_PUSH:   if (cnt_ff == 2'd2) state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || rsp_tready) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready   = 1'b0;
      root_start   = 1'b0;
      div_start    = 1'b0;
      div_dividend = qnum;
      div_divisor  = root_w;
      case (state_ff)
         S_IDLE: req_tready = !reset;
         S_DGO,
         S_NGO:  root_start = 1'b1;
         S_QGO:  div_start = 1'b1;
         S_RGO: begin
            div_start    = 1'b1;
            div_dividend = rnum;
            div_divisor  = DIV_VW'(p_ff);
         end
         default: req_tready = 1'b0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      p_in         = csr_wr_en ? csr_wr_data : p_ff;
      same_in      = same_ff;
      held_in      = held_ff;
      dist_in      = dist_ff;
      ratio_in     = ratio_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      dacc_in      = dacc_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      for (int i = 0; i < 3; i++) begin
         heading_in[i] = heading_ff[i];
         u_in[i]       = u_ff[i];
         nm_in[i]      = nm_ff[i];
         neg_in[i]     = neg_ff[i];
         nv_in[i]      = nv_ff[i];
         out_in[i]     = out_ff[i];
      end
      if (rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_DIFF: begin
            same_in = same_w;
            held_in = held_w;
            pass_in = 1'b0;
            cnt_in  = '0;
            dist_in = '1;
            for (int i = 0; i < 3; i++) nm_in[i] = NM_W'(dmag_w[i]);
         end
         S_DSQ,
         S_NSQ: begin
            // Squares go through a product register before they are summed.
            prod_in = sq_op * sq_op;
            acc_in  = (cnt_ff == 2'd0) ? '0 : acc_ff + ROOT_IN_W'(prod_ff);
            cnt_in  = cnt_ff + 2'd1;
         end
         S_DWAIT: if (root_done) dist_in = root_w;
         S_NLOAD: begin
            for (int i = 0; i < 3; i++) begin
               nm_in[i]  = pass_ff ? nvmag_w[i] : NM_W'(dmag_w[i]);
               neg_in[i] = pass_ff ? nv_ff[i][NV_W-1] : d_w[i][CRD_W];
            end
         end
         S_NSHIFT: begin
            cnt_in = '0;
            if (nz_w) begin
               for (int i = 0; i < 3; i++) begin
                  if (pass_ff) heading_in[i] = '0;
                  else u_in[i] = '0;
               end
            end else if (any_hi) begin
               for (int i = 0; i < 3; i++) nm_in[i] = nm_ff[i] >> 1;
            end else if (all_lo) begin
               for (int i = 0; i < 3; i++) nm_in[i] = nm_ff[i] << 1;
            end
         end
         S_NWAIT: cnt_in = '0;
         S_QWAIT: begin
            if (div_done) begin
               if (pass_ff) heading_in[idx] = o16;
               else u_in[idx] = o16;
               cnt_in = cnt_ff + 2'd1;
            end
         end
         S_NEXT: begin
            cnt_in   = '0;
            phase_in = 1'b0;
            ratio_in = HONE[HD_W-1:0];
         end
         S_RWAIT: if (div_done) ratio_in = quot[HD_W-1:0];
         S_BLEND: begin
            phase_in = !phase_ff;
            dacc_in  = '0;
            if (!phase_ff) begin
               nv_in[idx] = NV_W'(mul_p);
            end else begin
               nv_in[idx] = nv_ff[idx] + NV_W'(mul_p);
               cnt_in     = (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
            end
         end
         S_DOT: begin
            dacc_in = dsum;
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               cnt_in  = '0;
               dacc_in = '0;
               pass_in = 1'b1;
            end
         end
         S_PERP: begin
            dacc_in = dsum;
            cnt_in  = cnt_ff + 2'd1;
            if (cnt_ff == 2'd2) begin
               // Turn the perpendicular so that it faces the blended heading.
               for (int i = 0; i < 3; i++) begin
                  if (dsum < 0 && i != 2) nv_in[i] = NV_W'(-t_w[i]);
                  else nv_in[i] = NV_W'(t_w[i]);
               end
               cnt_in = '0;
            end
         end
         S_PUSH: begin
            if (po_w[NV_W-1] && po_w[NV_W-1:CRD_W-1] != '1) out_in[idx] = 32'h8000_0000;
            else if (!po_w[NV_W-1] && po_w[NV_W-1:CRD_W-1] != '0) out_in[idx] = 32'h7fff_ffff;
            else out_in[idx] = po_w[CRD_W-1:0];
            cnt_in = (cnt_ff == 2'd2) ? 2'd0 : cnt_ff + 2'd1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {out_ff[2], out_ff[1], out_ff[0]};
            end
         end
         default: cnt_in = cnt_ff;
      endcase
      // Nine coordinates are unpacked from the input transfer in a later block.
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < 3; i++) begin
            goal_ff[i]  <= req_tdata[i*CRD_W +: CRD_W];
            prev_ff[i]  <= req_tdata[(3+i)*CRD_W +: CRD_W];
            robot_ff[i] <= req_tdata[(6+i)*CRD_W +: CRD_W];
         end
      end
      for (int i = 0; i < 3; i++) begin
         u_ff[i]   <= u_in[i];
         nm_ff[i]  <= nm_in[i];
         neg_ff[i] <= neg_in[i];
         nv_ff[i]  <= nv_in[i];
         out_ff[i] <= out_in[i];
      end
      same_ff     <= same_in;
      held_ff     <= held_in;
      dist_ff     <= dist_in;
      ratio_ff    <= ratio_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      dacc_ff     <= dacc_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         p_ff         <= PD_RESET;
         cnt_ff       <= '0;
         phase_ff     <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) heading_ff[i] <= '0;
      end else begin
         state_ff     <= state_in;
         p_ff         <= p_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) heading_ff[i] <= heading_in[i];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result appeared outside the output state");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_DIFF)
      else $error("accepted item did not start the sequence");

   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_QWAIT || state_ff == S_RWAIT))
      else $error("divider finished while nobody waited");

   a_root_done_wait: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == S_DWAIT || state_ff == S_NWAIT))
      else $error("square root finished while nobody waited");

   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NSQ) |-> (nm_ff[0][NM_W-1:31] == '0 && nm_ff[1][NM_W-1:31] == '0
                               && nm_ff[2][NM_W-1:31] == '0))
      else $error("normalized magnitude above range");

endmodule

// ----- sv/wphp_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
module wphp_isqrt #(
   parameter int IN_W = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IN_W-1:0]     radicand,
   output logic                done,
   output logic [IN_W/2-1:0]   root
);
   localparam int RW = IN_W / 2;
   localparam int CW = $clog2(RW + 1);

   logic [IN_W-1:0] rad_ff, rad_in;
   logic [RW+1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in, done_ff, done_in;
   logic [RW+1:0]   shifted, trial;

   always_comb begin
      shifted = {rem_ff[RW-1:0], rad_ff[IN_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (shifted >= trial) begin
            rem_in  = shifted - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rad_in_hold: begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- sv/wphp_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module wphp_div #(
   parameter int DW = 48,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] dvd_ff, dvd_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [VW:0]   rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [VW:0]   shifted;

   always_comb begin
      shifted = {rem_ff[VW-1:0], dvd_ff[DW-1]};
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The dividend register doubles as the quotient register.
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            dvd_in = {dvd_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            dvd_in = {dvd_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ----- tb/waypoint_heading_projector_test.sv -----
// Self-checking testbench for the waypoint heading projector with its own heading predictor.
module waypoint_heading_projector_test;
   import wphp_pkg::*;

   localparam int HF = 14;
   localparam longint HONE = 64'sd1 << HF;
   localparam int CF = 16;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [9*CRD_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [3*CRD_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [P_W-1:0] csr_wr_data = '0;

   typedef struct packed {
      logic signed [31:0] z;
      logic signed [31:0] y;
      logic signed [31:0] x;
   } point_type;

   typedef struct {
      point_type goal;
      point_type prev;
      point_type robot;
      bit        has_exp;
      point_type exp;
   } stim_row_type;

   waypoint_heading_projector u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: projection distance and stored unit heading.
   longint unsigned proj_dist;
   int hdg [3];
   point_type projected_q [$];
   stim_row_type rows [$];
   int errors = 0;
   int sent = 0;
   int received = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned absval(longint v);
      return v < 0 ? -v : v;
   endfunction

   function automatic void unit_vector(input longint v [3], output int o [3]);
      longint unsigned m [3];
      longint unsigned mx, s, r, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = absval(v[i]);
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         o = '{0, 0, 0};
         return;
      end
      while (mx >= (64'd1 << 31)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
      s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      r = root64(s);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << HF) + (r >> 1)) / r;
         if (v[i] < 0) o[i] = q > 32768 ? -32768 : -int'(q);
         else o[i] = q > 32767 ? 32767 : int'(q);
      end
   endfunction

   function automatic point_type project_waypoint(point_type goal, point_type prev,
                                                  point_type robot);
      longint g [3], d [3], nv [3], t [3];
      longint dot, ratio, o, delta;
      longint unsigned span, mn, a;
      int u [3], nh [3];
      bit same, held, big;
      point_type res;
      g = '{goal.x, goal.y, goal.z};
      d = '{longint'(goal.x) - robot.x, longint'(goal.y) - robot.y,
            longint'(goal.z) - robot.z};
      big = 0;
      for (int i = 0; i < 3; i++) if (absval(d[i]) >= (64'd1 << 31)) big = 1;
      same = goal == prev;
      held = hdg[0] != 0 || hdg[1] != 0 || hdg[2] != 0;
      if (big) span = 64'hFFFF_FFFF;
      else span = root64(absval(d[0]) ** 2 + absval(d[1]) ** 2 + absval(d[2]) ** 2);
      unit_vector(d, u);
      if (same && held) begin
         if (proj_dist == 0) begin
            ratio = HONE;
         end else begin
            mn = 2 * span < proj_dist ? 2 * span : proj_dist;
            ratio = ((mn << HF) + (proj_dist >> 1)) / proj_dist;
         end
         for (int i = 0; i < 3; i++) nv[i] = longint'(u[i]) * ratio + longint'(hdg[i]) * (HONE - ratio);
      end else begin
         for (int i = 0; i < 3; i++) nv[i] = longint'(u[i]) * HONE;
      end
      dot = nv[0] * hdg[0] + nv[1] * hdg[1] + nv[2] * hdg[2];
      // A backward turn is replaced by the old heading's perpendicular.
      if (held && dot < 0) begin
         t = '{hdg[1], -longint'(hdg[0]), hdg[2]};
         if (t[0] * nv[0] + t[1] * nv[1] + t[2] * nv[2] < 0) begin
            t[0] = -t[0];
            t[1] = -t[1];
         end
         nv = t;
      end
      unit_vector(nv, nh);
      hdg = nh;
      for (int i = 0; i < 3; i++) begin
         o = g[i];
         if (span < proj_dist) begin
            a = absval(nh[i]) * (proj_dist - span);
            delta = (a + (64'd1 << (HF - 1))) >> HF;
            o += nh[i] < 0 ? -delta : delta;
         end
         if (o > 64'sd2147483647) o = 64'sd2147483647;
         if (o < -64'sd2147483648) o = -64'sd2147483648;
         case (i)
            0: res.x = o[31:0];
            1: res.y = o[31:0];
            default: res.z = o[31:0];
         endcase
      end
      return res;
   endfunction

   function automatic point_type make_point(longint x, longint y, longint z);
      point_type p;
      p.x = x[31:0];
      p.y = y[31:0];
      p.z = z[31:0];
      return p;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $signed($urandom_range(0, 40 << CF)) - (20 << CF);
      endcase
   endfunction

   task automatic add_row(point_type goal, point_type prev, point_type robot, bit has_exp,
                          point_type exp);
      stim_row_type row;
      row.goal    = goal;
      row.prev    = prev;
      row.robot   = robot;
      row.has_exp = has_exp;
      row.exp     = exp;
      rows = {rows, row};
   endtask

   // Called at a falling edge; leaves req_tvalid high after the transfer until the
   // next call or a drain decides what the channel does next.
   task automatic send_item(point_type goal, point_type prev, point_type robot);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata <= {robot, prev, goal};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      projected_q = {projected_q, project_waypoint(goal, prev, robot)};
      sent++;
      @(negedge clock);
   endtask

   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      while (projected_q.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_distance(longint unsigned value);
      csr_wr_data <= value[P_W-1:0];
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      proj_dist = value[P_W-1:0];
   endtask

   always @(negedge clock) rsp_tready <= $urandom_range(0, 99) >= recv_idle_pct;

   always @(posedge clock) begin
      point_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         received++;
         if (projected_q.size() == 0) begin
            $error("result transfer with no expected result");
            errors++;
         end else begin
            want = projected_q.pop_front();
            if (got.x !== want.x) begin
               $error("out_x expected %0d got %0d", want.x, got.x);
               errors++;
            end
            if (got.y !== want.y) begin
               $error("out_y expected %0d got %0d", want.y, got.y);
               errors++;
            end
            if (got.z !== want.z) begin
               $error("out_z expected %0d got %0d", want.z, got.z);
               errors++;
            end
         end
      end
   end

   initial begin
      #40_000_000;
      $display("** waypoint_heading_projector: FAILED **");
      $finish;
   end

   initial begin
      point_type g, p, r, o;
      int phase_items;
      proj_dist = ((64'd16 << CF) + 5) / 10;
      hdg = '{0, 0, 0};
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows; expectations typed in only where obvious.
      o = make_point(0, 0, 0);
      // Goal at robot with no heading: zero direction, goal passed through.
      add_row(o, make_point(1, 0, 0), o, 1, o);
      add_row(make_point(10 << CF, 0, 0), o, o, 1, make_point(10 << CF, 0, 0));
      // Unchanged goal near the robot: blended heading and push.
      add_row(make_point(1 << CF, 0, 0), make_point(1 << CF, 0, 0), o, 0, o);
      // Backward goal forces the perpendicular.
      add_row(make_point(-(5 << CF), 1000, 0), o, o, 0, o);
      add_row(make_point(0, 0, 3 << CF), make_point(0, 0, 3 << CF), o, 0, o);
      add_row(make_point(0, 0, 3 << CF), make_point(0, 0, 3 << CF),
              make_point(0, 0, 3 << CF), 0, o);
      // Extremes: large differences saturate the distance and the output.
      add_row(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF), o,
              make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, o);
      add_row(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
              make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000),
              make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 0, o);
      add_row(make_point(32'h7FFF_FFFF, 5, -5), make_point(32'h7FFF_FFFF, 5, -5),
              make_point(32'h7FFF_FFF0, 0, 0), 0, o);
      add_row(make_point(-1, -1, -1), make_point(-1, -1, -1), o, 0, o);
      add_row(make_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555),
              make_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA),
              make_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA), 0, o);
      foreach (rows[i]) begin
         send_item(rows[i].goal, rows[i].prev, rows[i].robot);
         if (rows[i].has_exp && projected_q[$] != rows[i].exp) begin
            $error("directed row %0d: predictor disagrees with typed result", i);
            errors++;
         end
      end
      drain(700);

      // Zero projection distance: direction only, no push.
      write_distance(0);
      send_item(make_point(1 << CF, 0, 0), make_point(1 << CF, 0, 0), o);
      send_item(make_point(1 << CF, 2, 0), make_point(1 << CF, 2, 0), o);
      drain(700);
      write_distance(1 << 20);
      send_item(make_point(3 << CF, 1 << CF, 0), make_point(3 << CF, 1 << CF, 0), o);
      send_item(make_point(32'h7FFF_FFFF, 0, 0), make_point(32'h7FFF_FFFF, 0, 0),
                make_point(32'h7FFF_0000, 0, 0));

      // Random phases, each with its own distance and idling pattern.
      p = make_point(rand_coord(), rand_coord(), rand_coord());
      for (int ph = 0; ph < 3; ph++) begin
         drain(700);
         write_distance(ph == 2 ? 21'h1F_FFFF : $urandom_range(1, 1 << 20));
         send_idle_pct = ph == 0 ? 35 : ph == 1 ? 74 : 0;
         recv_idle_pct = ph == 0 ? 74 : ph == 1 ? 35 : 0;
         phase_items = 380;
         g = make_point(rand_coord(), rand_coord(), rand_coord());
         for (int n = 0; n < phase_items; n++) begin
            // Mostly a robot walking toward a held goal, sometimes a new goal.
            if ($urandom_range(0, 9) < 2) begin
               p = g;
               g = make_point(rand_coord(), rand_coord(), rand_coord());
            end
            r = make_point(g.x - $signed($urandom_range(0, 8 << CF)) + (4 << CF),
                           g.y - $signed($urandom_range(0, 8 << CF)) + (4 << CF),
                           g.z - $signed($urandom_range(0, 2 << CF)) + (1 << CF));
            if ($urandom_range(0, 19) == 0) r = make_point(rand_coord(), rand_coord(), rand_coord());
            send_item(g, $urandom_range(0, 3) != 0 ? g : p, r);
            if (n == 150) drain(0);
         end
      end
      drain(700);

      $display("Sent %0d waypoints and checked %0d projected goals over three pacing phases.",
               sent, received);
      if (errors == 0) begin
         $display("** waypoint_heading_projector: PASSED **");
      end else begin
         $display("** waypoint_heading_projector: FAILED **");
      end
      $finish;
   end
endmodule

// ----- waypoint_heading_projector.f -----
sv/wphp_pkg.sv
sv/wphp_isqrt.sv
sv/wphp_div.sv
sv/waypoint_heading_projector.sv
tb/waypoint_heading_projector_test.sv
